>>> sv/rod_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the rotation matrix pipeline
// no dependencies
package rod_pkg;

    // pipeline step and term counts, and the reduction width
    localparam int SQ_STEPS     = 32;
    localparam int DIV_STEPS    = 31;
    localparam int RED_STEPS    = 8;
    localparam int HORNER_STEPS = 6;
    localparam int SIN_TERMS    = 5;
    localparam int T_W          = 38;

    localparam logic [30:0] HALF_PI = 31'h6487ED51;
    localparam logic [30:0] Q30_ONE = 31'h40000000;

    typedef logic [7:0] t_div8;
    typedef logic signed [32:0] t_q30;

    // taylor divisors n(n+1) and their floor(2^32 / d) reciprocals
    localparam t_div8 SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam t_div8 COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RCP [SIN_TERMS] = '{
        32'(33'h100000000 / 33'd110), 32'(33'h100000000 / 33'd72),
        32'(33'h100000000 / 33'd42), 32'(33'h100000000 / 33'd20),
        32'(33'h100000000 / 33'd6)};
    localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
        32'(33'h100000000 / 33'd132), 32'(33'h100000000 / 33'd90),
        32'(33'h100000000 / 33'd56), 32'(33'h100000000 / 33'd30),
        32'(33'h100000000 / 33'd12), 32'(33'h100000000 / 33'd2)};

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        ti;
    } t_root;

    typedef struct packed {
        t_q30 ux;
        t_q30 uy;
        t_q30 uz;
        logic zero;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [31:0] ti;
    } t_norm;

    typedef struct packed {
        t_side side;
        t_q30  s;
        t_q30  c;
    } t_trig;

    // unsigned q30 product, rounded half up
    function automatic logic [31:0] umul30(input logic [31:0] a, input logic [31:0] b);
        logic [64:0] p;
        p = 65'(a) * 65'(b) + (65'd1 << 29);
        return p[61:30];
    endfunction

    // signed q30 product, magnitude rounded half up
    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        logic [32:0] ma;
        logic [32:0] mb;
        logic [65:0] p;
        logic [32:0] m;
        ma = a[32] ? 33'(-a) : 33'(a);
        mb = b[32] ? 33'(-b) : 33'(b);
        p  = 66'(ma) * 66'(mb) + (66'd1 << 29);
        m  = p[62:30];
        return (a[32] ^ b[32]) ? -$signed(m) : $signed(m);
    endfunction

endpackage

>>> sv/rod_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: axis-angle input and rotation matrix output
// no dependencies
interface rod_vec_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface rod_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               was_identity;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    was_identity, input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  was_identity, output ready);
endinterface

>>> sv/axis_angle_to_rotation_matrix.sv
`timescale 1ns / 1ps
// axis-angle vector to 3x3 rotation matrix, fully pipelined
// depends on rod_pkg, rod_if, rod_sqrt, rod_div, rod_trig, rod_mat
//
//  channel  direction  payload                              handshake
//  i_vec    in         vec_x, vec_y, vec_z (Q3.12)          valid / ready
//  o_mat    out        r00..r22 (Q1.14), was_identity       valid / ready
//
// one item per cycle while the output is not stalled; the stages in order: the norm
// and square root, the three unit-axis dividers, angle reduction and sine/cosine,
// then the matrix products and the output register.
// synchronous active-low reset clears all stage valid bits.
// the whole pipeline advances while the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
module axis_angle_to_rotation_matrix #(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rod_vec_if.sink   i_vec,
    rod_mat_if.source o_mat
);
    import rod_pkg::*;

    localparam logic [15:0] ONE_OUT = 16'(36'd1 << OUT_FRAC_BITS);

    logic             w_en;
    logic             w_sq_vld;
    t_root            w_root;
    logic             w_dv_vld;
    t_norm            w_norm;
    logic             w_tr_vld;
    t_trig            w_trig;
    logic             w_out_vld;
    logic [8:0][15:0] w_r;
    logic             w_ident;

    // global advance
    assign w_en        = !w_out_vld || o_mat.ready;
    assign i_vec.ready = w_en;

    rod_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_vec.valid),
        .i_x     (i_vec.vec_x),
        .i_y     (i_vec.vec_y),
        .i_z     (i_vec.vec_z),
        .o_vld   (w_sq_vld),
        .o_root  (w_root)
    );

    rod_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_root  (w_root),
        .o_vld   (w_dv_vld),
        .o_norm  (w_norm)
    );

    rod_trig #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dv_vld),
        .i_norm  (w_norm),
        .o_vld   (w_tr_vld),
        .o_trig  (w_trig)
    );

    rod_mat #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_tr_vld),
        .i_trig  (w_trig),
        .o_vld   (w_out_vld),
        .o_r     (w_r),
        .o_ident (w_ident)
    );

    // output channel
    assign o_mat.valid        = w_out_vld;
    assign o_mat.r00          = $signed(w_r[0]);
    assign o_mat.r01          = $signed(w_r[1]);
    assign o_mat.r02          = $signed(w_r[2]);
    assign o_mat.r10          = $signed(w_r[3]);
    assign o_mat.r11          = $signed(w_r[4]);
    assign o_mat.r12          = $signed(w_r[5]);
    assign o_mat.r20          = $signed(w_r[6]);
    assign o_mat.r21          = $signed(w_r[7]);
    assign o_mat.r22          = $signed(w_r[8]);
    assign o_mat.was_identity = w_ident;

`ifndef ASSERT_OFF
    // a held result must back-pressure the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid && !o_mat.ready |-> !i_vec.ready)
        else $error("input accepted while result is stalled");

    // zero vector gives exactly the identity
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid && o_mat.was_identity |->
            o_mat.r00 == ONE_OUT && o_mat.r11 == ONE_OUT && o_mat.r22 == ONE_OUT &&
            o_mat.r01 == 16'd0 && o_mat.r02 == 16'd0 && o_mat.r10 == 16'd0 &&
            o_mat.r12 == 16'd0 && o_mat.r20 == 16'd0 && o_mat.r21 == 16'd0)
        else $error("identity flag without identity matrix");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_mat.valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> sv/rod_sqrt.sv
`timescale 1ns / 1ps
// squared norm and pipelined integer square root, one result bit per stage
// depends on rod_pkg
module rod_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    output logic               o_vld,
    output rod_pkg::t_root     o_root
);
    import rod_pkg::*;

    typedef struct packed {
        logic [63:0]        rad;
        logic [63:0]        res;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_sq_stage;

    logic [SQ_STEPS:0] r_vld;
    t_sq_stage         r_st [SQ_STEPS+1];
    t_sq_stage         n_st [SQ_STEPS+1];
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic signed [31:0] w_pz;
    logic [33:0]        w_t2;

    // squares, then one restoring root step per stage
    always_comb begin
        w_px = i_x * i_x;
        w_py = i_y * i_y;
        w_pz = i_z * i_z;
        w_t2 = 34'($unsigned(w_px)) + 34'($unsigned(w_py)) + 34'($unsigned(w_pz));
        n_st[0].rad = 64'(w_t2) << 30;
        n_st[0].res = '0;
        n_st[0].x   = i_x;
        n_st[0].y   = i_y;
        n_st[0].z   = i_z;
        for (int k = 0; k < SQ_STEPS; k++) begin
            n_st[k+1] = r_st[k];
            if (r_st[k].rad >= r_st[k].res + (64'd1 << (62 - 2 * k))) begin
                n_st[k+1].rad = r_st[k].rad - (r_st[k].res + (64'd1 << (62 - 2 * k)));
                n_st[k+1].res = (r_st[k].res >> 1) + (64'd1 << (62 - 2 * k));
            end else begin
                n_st[k+1].res = r_st[k].res >> 1;
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STEPS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld     = r_vld[SQ_STEPS];
    assign o_root.x  = r_st[SQ_STEPS].x;
    assign o_root.y  = r_st[SQ_STEPS].y;
    assign o_root.z  = r_st[SQ_STEPS].z;
    assign o_root.ti = r_st[SQ_STEPS].res[31:0];

endmodule

>>> sv/rod_div.sv
`timescale 1ns / 1ps
// unit axis: three pipelined restoring dividers, one quotient bit per stage
// depends on rod_pkg
module rod_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  rod_pkg::t_root i_root,
    output logic           o_vld,
    output rod_pkg::t_norm o_norm
);
    import rod_pkg::*;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] low;
        logic [30:0] quo;
        logic        neg;
    } t_lane;

    typedef struct packed {
        t_lane [2:0] ln;
        logic [31:0] ti;
        logic        zero;
    } t_dv_stage;

    logic [DIV_STEPS:0] r_vld;
    t_dv_stage          r_st [DIV_STEPS+1];
    t_dv_stage          n_st [DIV_STEPS+1];
    logic signed [15:0] w_v [3];
    logic [15:0]        w_mag [3];
    logic [60:0]        w_num [3];

    // numerators with half-divisor rounding, then one quotient bit per stage
    always_comb begin
        w_v[0] = i_root.x;
        w_v[1] = i_root.y;
        w_v[2] = i_root.z;
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = w_v[l][15] ? 16'(-w_v[l]) : 16'(w_v[l]);
            w_num[l] = {w_mag[l], 45'd0} + 61'(i_root.ti >> 1);
            n_st[0].ln[l].rem = 33'(w_num[l][60:31]);
            n_st[0].ln[l].low = w_num[l][30:0];
            n_st[0].ln[l].quo = '0;
            n_st[0].ln[l].neg = w_v[l][15];
        end
        n_st[0].ti   = i_root.ti;
        n_st[0].zero = (i_root.x == 16'sd0) && (i_root.y == 16'sd0) && (i_root.z == 16'sd0);
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_st[k+1] = r_st[k];
            for (int l = 0; l < 3; l++) begin
                if ({r_st[k].ln[l].rem[31:0], r_st[k].ln[l].low[DIV_STEPS-1-k]}
                        >= {1'b0, r_st[k].ti}) begin
                    n_st[k+1].ln[l].rem = {r_st[k].ln[l].rem[31:0],
                                           r_st[k].ln[l].low[DIV_STEPS-1-k]}
                                          - {1'b0, r_st[k].ti};
                    n_st[k+1].ln[l].quo[DIV_STEPS-1-k] = 1'b1;
                end else begin
                    n_st[k+1].ln[l].rem = {r_st[k].ln[l].rem[31:0],
                                           r_st[k].ln[l].low[DIV_STEPS-1-k]};
                end
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // signed unit components
    assign o_vld = r_vld[DIV_STEPS];
    assign o_norm.side.ux = r_st[DIV_STEPS].ln[0].neg ?
        -$signed({2'b00, r_st[DIV_STEPS].ln[0].quo}) : $signed({2'b00, r_st[DIV_STEPS].ln[0].quo});
    assign o_norm.side.uy = r_st[DIV_STEPS].ln[1].neg ?
        -$signed({2'b00, r_st[DIV_STEPS].ln[1].quo}) : $signed({2'b00, r_st[DIV_STEPS].ln[1].quo});
    assign o_norm.side.uz = r_st[DIV_STEPS].ln[2].neg ?
        -$signed({2'b00, r_st[DIV_STEPS].ln[2].quo}) : $signed({2'b00, r_st[DIV_STEPS].ln[2].quo});
    assign o_norm.side.zero = r_st[DIV_STEPS].zero;
    assign o_norm.ti = r_st[DIV_STEPS].ti;

endmodule

>>> sv/rod_trig.sv
`timescale 1ns / 1ps
// angle scaling, quadrant reduction and pipelined taylor sine/cosine
// depends on rod_pkg
module rod_trig #(
    parameter int IN_FRAC_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  rod_pkg::t_norm i_norm,
    output logic           o_vld,
    output rod_pkg::t_trig o_trig
);
    import rod_pkg::*;

    localparam int TF  = IN_FRAC_BITS + 15;
    localparam int NH  = 3 * HORNER_STEPS;
    localparam int LAT = RED_STEPS + NH + 4;

    typedef struct packed {
        logic [T_W-1:0] rem;
        logic [1:0]     q;
        t_side          side;
    } t_red;

    typedef struct packed {
        logic [30:0] r;
        logic        rneg;
        logic [1:0]  q;
        t_side       side;
    } t_ang;

    typedef struct packed {
        logic [30:0] r;
        logic [30:0] r2;
        logic        rneg;
        logic [1:0]  q;
        logic [30:0] sacc;
        logic [30:0] cacc;
        logic [31:0] sp;
        logic [31:0] cp;
        logic [63:0] se;
        logic [63:0] ce;
        t_side       side;
    } t_hor;

    logic [LAT-1:0] r_vld;
    t_red           r_red [RED_STEPS+1];
    t_red           n_red [RED_STEPS+1];
    t_ang           r_ang;
    t_ang           n_ang;
    t_hor           r_h [NH+1];
    t_hor           n_h [NH+1];
    t_trig          r_q;
    t_trig          n_q;
    logic [T_W-1:0] w_t;
    logic [30:0]    w_r;
    t_q30           w_sr;
    t_q30           w_cr;

    // fixed correction of a reciprocal quotient, then 1 - quotient
    function automatic logic [30:0] horner_fix(input logic [31:0] p, input logic [63:0] e,
                                               input logic [7:0] d);
        logic [31:0] q0;
        logic [39:0] rem;
        q0  = e[63:32];
        rem = 40'(p) - 40'(q0) * 40'(d);
        if (rem >= 40'(d)) begin
            q0 = q0 + 32'd1;
        end
        return 31'(33'(Q30_ONE) - 33'(q0));
    endfunction

    // norm to q30
    generate
        if (TF > 30) begin : g_shr
            logic [32:0] w_sum;
            assign w_sum = 33'(i_norm.ti) + (33'd1 << (TF - 31));
            assign w_t   = T_W'(w_sum >> (TF - 30));
        end else begin : g_shl
            assign w_t = T_W'(i_norm.ti) << (30 - TF);
        end
    endgenerate

    // reduction by half pi, one quotient bit per stage
    always_comb begin
        n_red[0].rem  = w_t;
        n_red[0].q    = '0;
        n_red[0].side = i_norm.side;
        for (int k = 0; k < RED_STEPS; k++) begin
            n_red[k+1] = r_red[k];
            if (r_red[k].rem >= (T_W'(HALF_PI) << (RED_STEPS - 1 - k))) begin
                n_red[k+1].rem = r_red[k].rem - (T_W'(HALF_PI) << (RED_STEPS - 1 - k));
                if (RED_STEPS - 1 - k < 2) begin
                    n_red[k+1].q[(RED_STEPS - 1 - k) % 2] = 1'b1;
                end
            end
        end
    end

    // fold into plus or minus quarter pi
    always_comb begin
        w_r          = r_red[RED_STEPS].rem[30:0];
        n_ang.side   = r_red[RED_STEPS].side;
        n_ang.r      = w_r;
        n_ang.rneg   = 1'b0;
        n_ang.q      = r_red[RED_STEPS].q;
        if ({w_r, 1'b0} > {1'b0, HALF_PI}) begin
            n_ang.r    = HALF_PI - w_r;
            n_ang.rneg = 1'b1;
            n_ang.q    = r_red[RED_STEPS].q + 2'd1;
        end
    end

    // horner evaluation: multiply, reciprocal multiply, correct
    always_comb begin
        n_h[0].r    = r_ang.r;
        n_h[0].r2   = 31'(umul30(32'(r_ang.r), 32'(r_ang.r)));
        n_h[0].rneg = r_ang.rneg;
        n_h[0].q    = r_ang.q;
        n_h[0].sacc = Q30_ONE;
        n_h[0].cacc = Q30_ONE;
        n_h[0].sp   = '0;
        n_h[0].cp   = '0;
        n_h[0].se   = '0;
        n_h[0].ce   = '0;
        n_h[0].side = r_ang.side;
        for (int k = 0; k < HORNER_STEPS; k++) begin
            n_h[3*k+1]    = r_h[3*k];
            n_h[3*k+1].cp = umul30(32'(r_h[3*k].r2), 32'(r_h[3*k].cacc))
                            + 32'(COS_DIV[k] >> 1);
            if (k < SIN_TERMS) begin
                n_h[3*k+1].sp = umul30(32'(r_h[3*k].r2), 32'(r_h[3*k].sacc))
                                + 32'(SIN_DIV[(k < SIN_TERMS) ? k : 0] >> 1);
            end else begin
                n_h[3*k+1].sp = umul30(32'(r_h[3*k].r), 32'(r_h[3*k].sacc));
            end

            n_h[3*k+2]    = r_h[3*k+1];
            n_h[3*k+2].ce = 64'(r_h[3*k+1].cp) * 64'(COS_RCP[k]);
            if (k < SIN_TERMS) begin
                n_h[3*k+2].se = 64'(r_h[3*k+1].sp)
                                * 64'(SIN_RCP[(k < SIN_TERMS) ? k : 0]);
            end

            n_h[3*k+3]      = r_h[3*k+2];
            n_h[3*k+3].cacc = horner_fix(r_h[3*k+2].cp, r_h[3*k+2].ce, COS_DIV[k]);
            if (k < SIN_TERMS) begin
                n_h[3*k+3].sacc = horner_fix(r_h[3*k+2].sp, r_h[3*k+2].se,
                                             SIN_DIV[(k < SIN_TERMS) ? k : 0]);
            end else begin
                n_h[3*k+3].sacc = r_h[3*k+2].sp[30:0];
            end
        end
    end

    // quadrant map
    always_comb begin
        w_sr = r_h[NH].rneg ? -$signed({2'b00, r_h[NH].sacc}) : $signed({2'b00, r_h[NH].sacc});
        w_cr = $signed({2'b00, r_h[NH].cacc});
        n_q.side = r_h[NH].side;
        case (r_h[NH].q)
            2'd0: begin
                n_q.s = w_sr;
                n_q.c = w_cr;
            end
            2'd1: begin
                n_q.s = w_cr;
                n_q.c = -w_sr;
            end
            2'd2: begin
                n_q.s = -w_sr;
                n_q.c = -w_cr;
            end
            default: begin
                n_q.s = -w_cr;
                n_q.c = w_sr;
            end
        endcase
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= RED_STEPS; k++) begin
                r_red[k] <= n_red[k];
            end
            r_ang <= n_ang;
            for (int k = 0; k <= NH; k++) begin
                r_h[k] <= n_h[k];
            end
            r_q <= n_q;
        end
    end

    assign o_vld  = r_vld[LAT-1];
    assign o_trig = r_q;

endmodule

>>> sv/rod_mat.sv
`timescale 1ns / 1ps
// matrix assembly: outer products, scaling, sums, rounding and saturation
// depends on rod_pkg
module rod_mat #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  rod_pkg::t_trig   i_trig,
    output logic             o_vld,
    output logic [8:0][15:0] o_r,
    output logic             o_ident
);
    import rod_pkg::*;

    localparam int RND_SH = (OUT_FRAC_BITS < 30) ? 30 - OUT_FRAC_BITS : 0;
    localparam logic [15:0] ONE_OUT = 16'(36'd1 << OUT_FRAC_BITS);

    typedef struct packed {
        t_q30 uxx;
        t_q30 uyy;
        t_q30 uzz;
        t_q30 uxy;
        t_q30 uxz;
        t_q30 uyz;
        t_q30 sx;
        t_q30 sy;
        t_q30 sz;
        t_q30 c;
        t_q30 d;
        logic zero;
    } t_m1;

    typedef struct packed {
        t_q30 xx;
        t_q30 yy;
        t_q30 zz;
        t_q30 xy;
        t_q30 xz;
        t_q30 yz;
        t_q30 sx;
        t_q30 sy;
        t_q30 sz;
        t_q30 c;
        logic zero;
    } t_m2;

    logic [2:0]       r_vld;
    t_m1              r_m1;
    t_m1              n_m1;
    t_m2              r_m2;
    t_m2              n_m2;
    logic [8:0][15:0] r_r;
    logic [8:0][15:0] n_r;
    logic             r_ident;

    // round to the output format and saturate to plus or minus one
    function automatic logic [15:0] pack(input logic signed [34:0] a);
        logic [34:0]        m;
        logic [34:0]        lim;
        logic signed [35:0] v;
        m   = a[34] ? 35'(-a) : 35'(a);
        m   = (m + ((35'd1 << RND_SH) >> 1)) >> RND_SH;
        lim = 35'd1 << OUT_FRAC_BITS;
        if (m > lim) begin
            m = lim;
        end
        v = a[34] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return v[15:0];
    endfunction

    // axis outer products and sine terms
    always_comb begin
        n_m1.uxx  = qmul(i_trig.side.ux, i_trig.side.ux);
        n_m1.uyy  = qmul(i_trig.side.uy, i_trig.side.uy);
        n_m1.uzz  = qmul(i_trig.side.uz, i_trig.side.uz);
        n_m1.uxy  = qmul(i_trig.side.ux, i_trig.side.uy);
        n_m1.uxz  = qmul(i_trig.side.ux, i_trig.side.uz);
        n_m1.uyz  = qmul(i_trig.side.uy, i_trig.side.uz);
        n_m1.sx   = qmul(i_trig.s, i_trig.side.ux);
        n_m1.sy   = qmul(i_trig.s, i_trig.side.uy);
        n_m1.sz   = qmul(i_trig.s, i_trig.side.uz);
        n_m1.c    = i_trig.c;
        n_m1.d    = $signed({2'b00, Q30_ONE}) - i_trig.c;
        n_m1.zero = i_trig.side.zero;
    end

    // scale by one minus cosine
    always_comb begin
        n_m2.xx   = qmul(r_m1.d, r_m1.uxx);
        n_m2.yy   = qmul(r_m1.d, r_m1.uyy);
        n_m2.zz   = qmul(r_m1.d, r_m1.uzz);
        n_m2.xy   = qmul(r_m1.d, r_m1.uxy);
        n_m2.xz   = qmul(r_m1.d, r_m1.uxz);
        n_m2.yz   = qmul(r_m1.d, r_m1.uyz);
        n_m2.sx   = r_m1.sx;
        n_m2.sy   = r_m1.sy;
        n_m2.sz   = r_m1.sz;
        n_m2.c    = r_m1.c;
        n_m2.zero = r_m1.zero;
    end

    // entries, identity on a zero vector
    always_comb begin
        if (r_m2.zero) begin
            n_r = '0;
            n_r[0] = ONE_OUT;
            n_r[4] = ONE_OUT;
            n_r[8] = ONE_OUT;
        end else begin
            n_r[0] = pack(35'(r_m2.c) + 35'(r_m2.xx));
            n_r[1] = pack(35'(r_m2.xy) - 35'(r_m2.sz));
            n_r[2] = pack(35'(r_m2.xz) + 35'(r_m2.sy));
            n_r[3] = pack(35'(r_m2.xy) + 35'(r_m2.sz));
            n_r[4] = pack(35'(r_m2.c) + 35'(r_m2.yy));
            n_r[5] = pack(35'(r_m2.yz) - 35'(r_m2.sx));
            n_r[6] = pack(35'(r_m2.xz) - 35'(r_m2.sy));
            n_r[7] = pack(35'(r_m2.yz) + 35'(r_m2.sx));
            n_r[8] = pack(35'(r_m2.c) + 35'(r_m2.zz));
        end
    end

    // stage registers, the last one is the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_r     <= n_r;
            r_ident <= r_m2.zero;
        end
    end

    assign o_vld   = r_vld[2];
    assign o_r     = r_r;
    assign o_ident = r_ident;

endmodule

>>> dv/tb_axis_angle_to_rotation_matrix.sv
`timescale 1ns / 1ps
// testbench for axis_angle_to_rotation_matrix: directed table, then random vectors
// checked against a bit-exact rodrigues predictor; depends on rod_if and axis_angle_to_rotation_matrix
module tb_axis_angle_to_rotation_matrix;

    localparam int IN_FB      = 12;
    localparam int OUT_FB     = 14;
    localparam int LATENCY    = 98;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 1130;

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} t_phase;

    typedef struct packed {
        logic [8:0][15:0] r;
        logic             ident;
    } t_matrix;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 known;
        t_matrix            m;
    } t_vec_row;

    localparam logic [63:0] HP64  = 64'h6487ED51;
    localparam logic [63:0] ONE64 = 64'h40000000;

    logic i_clk;
    logic i_rst_n;
    rod_vec_if vec_ch ();
    rod_mat_if mat_ch ();

    axis_angle_to_rotation_matrix #(.IN_FRAC_BITS(IN_FB), .OUT_FRAC_BITS(OUT_FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vec  (vec_ch.sink),
        .o_mat  (mat_ch.source)
    );

    t_matrix matrix_q[$];
    int      n_err;
    int      n_sent;
    int      n_got;
    int      n_ident;
    int      idle_cycles;
    t_phase  phase;
    bit      hold_sink;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint smul(input longint a, input longint b);
        logic [63:0] p;
        p = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] umul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // round to the output format and clamp to plus or minus one
    function automatic logic [15:0] to_entry(input longint v);
        logic [63:0] m;
        longint      s;
        m = mag(v);
        m = (m + (64'd1 << (29 - OUT_FB))) >> (30 - OUT_FB);
        if (m > (64'd1 << OUT_FB)) m = 64'd1 << OUT_FB;
        s = (v < 0) ? -longint'(m) : longint'(m);
        return s[15:0];
    endfunction

    // rodrigues formula in q30 fixed point
    function automatic t_matrix rotation_of(input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic signed [15:0] z);
        t_matrix     m;
        longint      v[3];
        longint      u[3];
        longint      s, c, d, sr, xx, yy, zz, xy, xz, yz, sx, sy, sz;
        logic [63:0] t2, ti, t, q, rr, r2, acc, sm;
        logic [63:0] sdiv[5];
        logic [63:0] cdiv[6];
        bit          rneg;
        int          tf;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        rneg = 0;
        tf   = IN_FB + 15;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        t2 = mag(v[0]) * mag(v[0]) + mag(v[1]) * mag(v[1]) + mag(v[2]) * mag(v[2]);
        if (t2 == 0) begin
            for (int i = 0; i < 9; i++) m.r[i] = (i % 4 == 0) ? 16'(1 << OUT_FB) : 16'd0;
            m.ident = 1'b1;
            return m;
        end
        ti = isqrt(t2 << 30);
        if (tf > 30) t = (ti + (64'd1 << (tf - 31))) >> (tf - 30);
        else if (tf == 30) t = ti;
        else t = ti << (30 - tf);
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'(((mag(v[i]) << 45) + (ti >> 1)) / ti);
            if (v[i] < 0) u[i] = -u[i];
        end
        q  = t / HP64;
        rr = t - q * HP64;
        if (2 * rr > HP64) begin
            rr   = HP64 - rr;
            rneg = 1;
            q    = q + 1;
        end
        r2  = umul(rr, rr);
        acc = ONE64;
        for (int i = 0; i < 5; i++) acc = ONE64 - (umul(r2, acc) + sdiv[i] / 2) / sdiv[i];
        sm  = umul(rr, acc);
        acc = ONE64;
        for (int i = 0; i < 6; i++) acc = ONE64 - (umul(r2, acc) + cdiv[i] / 2) / cdiv[i];
        sr = rneg ? -longint'(sm) : longint'(sm);
        case (q[1:0])
            2'd0: begin s = sr; c = longint'(acc); end
            2'd1: begin s = longint'(acc); c = -sr; end
            2'd2: begin s = -sr; c = -longint'(acc); end
            default: begin s = -longint'(acc); c = sr; end
        endcase
        d  = longint'(ONE64) - c;
        xx = smul(d, smul(u[0], u[0]));
        yy = smul(d, smul(u[1], u[1]));
        zz = smul(d, smul(u[2], u[2]));
        xy = smul(d, smul(u[0], u[1]));
        xz = smul(d, smul(u[0], u[2]));
        yz = smul(d, smul(u[1], u[2]));
        sx = smul(s, u[0]);
        sy = smul(s, u[1]);
        sz = smul(s, u[2]);
        m.r[0] = to_entry(c + xx);
        m.r[1] = to_entry(xy - sz);
        m.r[2] = to_entry(xz + sy);
        m.r[3] = to_entry(xy + sz);
        m.r[4] = to_entry(c + yy);
        m.r[5] = to_entry(yz - sx);
        m.r[6] = to_entry(xz - sy);
        m.r[7] = to_entry(yz + sx);
        m.r[8] = to_entry(c + zz);
        m.ident = 1'b0;
        return m;
    endfunction

    function automatic bit idle_roll(input t_phase p, input bit src);
        case (p)
            PH_SRC_IDLE:  return src && ($urandom_range(99) < 83);
            PH_SNK_STALL: return !src && ($urandom_range(99) < 83);
            PH_BOTH:      return $urandom_range(99) < 10;
            default:      return 1'b0;
        endcase
    endfunction

    // drive one item, wait for acceptance, queue its expected matrix
    task automatic send_vec(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] z, input bit known,
                            input t_matrix typed);
        t_matrix m;
        m = rotation_of(x, y, z);
        if (known && m != typed) begin
            $display("%0t directed row disagrees with predictor: expected %h got %h",
                     $time, typed, m);
            n_err++;
        end
        while (idle_roll(phase, 1'b1)) begin
            vec_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= x;
        vec_ch.vec_y <= y;
        vec_ch.vec_z <= z;
        matrix_q.push_back(m);
        @(posedge i_clk);
        while (!vec_ch.ready) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    // sender goes quiet until every expected result is back
    task automatic drain();
        vec_ch.valid <= 1'b0;
        while (matrix_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return 16'($urandom_range(64)) - 16'sd32;
            3, 4:    return 16'($urandom_range(4096)) - 16'sd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver ready, with a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) mat_ch.ready <= 1'b0;
        else mat_ch.ready <= !hold_sink && !idle_roll(phase, 1'b0);
    end

    // checker
    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix exp_m;
        if (i_rst_n && mat_ch.valid && mat_ch.ready) begin
            got.r[0] = mat_ch.r00; got.r[1] = mat_ch.r01; got.r[2] = mat_ch.r02;
            got.r[3] = mat_ch.r10; got.r[4] = mat_ch.r11; got.r[5] = mat_ch.r12;
            got.r[6] = mat_ch.r20; got.r[7] = mat_ch.r21; got.r[8] = mat_ch.r22;
            got.ident = mat_ch.was_identity;
            n_got++;
            if (matrix_q.size() == 0) begin
                $display("%0t unexpected matrix: expected none got %h", $time, got);
                n_err++;
            end else begin
                exp_m = matrix_q.pop_front();
                if (got.ident) n_ident++;
                for (int i = 0; i < 9; i++)
                    if (got.r[i] !== exp_m.r[i]) begin
                        $display("%0t entry r%0d%0d: expected %0d got %0d", $time, i / 3,
                                 i % 3, $signed(exp_m.r[i]), $signed(got.r[i]));
                        n_err++;
                    end
                if (got.ident !== exp_m.ident) begin
                    $display("%0t was_identity: expected %b got %b", $time, exp_m.ident,
                             got.ident);
                    n_err++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((vec_ch.valid && vec_ch.ready) || (mat_ch.valid && mat_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // sender holds off the receiver for a long stretch
    task automatic long_hold();
        hold_sink = 1'b1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                for (int i = 0; i < 150; i++) send_vec(rand_comp(), rand_comp(), rand_comp(),
                                                       1'b0, '0);
            end
        join
    endtask

    t_vec_row rows[$];
    t_matrix  ident_m;

    initial begin
        t_vec_row row;
        n_err        = 0;
        n_sent       = 0;
        n_got        = 0;
        n_ident      = 0;
        idle_cycles  = 0;
        hold_sink    = 1'b0;
        phase        = PH_FREE;
        i_rst_n      = 1'b0;
        vec_ch.valid = 1'b0;
        vec_ch.vec_x = '0;
        vec_ch.vec_y = '0;
        vec_ch.vec_z = '0;
        mat_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero vector gives the identity with the flag set
        for (int i = 0; i < 9; i++) ident_m.r[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
        ident_m.ident = 1'b1;
        row = '{0, 0, 0, 1, ident_m};
        rows.push_back(row);
        rows.push_back(row);
        // extremes, single-lsb norms, one radian, pi, quadrant edges
        begin
            logic signed [15:0] dv[18][3];
            dv = '{'{16'sh7FFF, 0, 0}, '{-16'sh8000, 0, 0}, '{0, 16'sh7FFF, 0},
                   '{0, 0, -16'sh8000}, '{1, 0, 0}, '{0, -1, 0}, '{0, 0, 1},
                   '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '{-16'sh8000, -16'sh8000, -16'sh8000},
                   '{4096, 0, 0}, '{0, 12868, 0}, '{0, 0, 6434}, '{19302, 0, 0},
                   '{-25736, 0, 0}, '{3, -5, 7}, '{16'sh7FFF, -16'sh8000, 1},
                   '{2364, 2364, 2364}, '{-1, -1, -1}};
            foreach (dv[i])
                rows.push_back(t_vec_row'{dv[i][0], dv[i][1], dv[i][2], 1'b0, '0});
        end
        foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].m);
        drain();

        // random part across handshake phases
        for (int p = 0; p < 4; p++) begin
            phase = t_phase'(p);
            for (int i = 0; i < N_RANDOM / 5; i++)
                send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
            drain();
        end
        phase = PH_BOTH;
        long_hold();
        phase = PH_FREE;
        for (int i = 0; i < N_RANDOM / 5 - 150; i++) begin
            if ($urandom_range(15) == 0) phase = t_phase'($urandom_range(3));
            send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
        end

        // wait for the tail, then a little extra for stray results
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d vectors, checked %0d matrices (%0d identity), %0d mismatches",
                 n_sent, n_got, n_ident, n_err);
        if (n_err == 0 && matrix_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
